@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// property that holds in the cycle after reset is sampled low
`define ASSERT_AFTER_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("assertion failed: state after reset");

`endif

@@ rtl/iardc_pkg.sv @@
// ----------------------------------------------------------------------------
// iardc_pkg
// Types, widths and reset values for the input axis ramp/decay/clamp block.
// ----------------------------------------------------------------------------
package iardc_pkg;

    localparam int DATA_W         = 16;
    localparam int CTRL_W         = 4;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int VALUE_BITS_DEF = 16;
    // working width for sums and scaled products, wide enough for VALUE_BITS up to 32
    localparam int WORK_W         = 42;
    localparam int MUL_W          = 18;

    // input word: tick, present, down, move, sample
    localparam int IN_FIELDS_W    = 3 * DATA_W + 2;
    localparam int S_TDATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = DATA_W;

    typedef enum logic [2:0] {
        MODE_MOVE       = 3'd0,
        MODE_MOUSE_BTN  = 3'd1,
        MODE_SCROLL     = 3'd2,
        MODE_KEY        = 3'd3,
        MODE_STICK_AXIS = 3'd4,
        MODE_STICK_BTN  = 3'd5,
        MODE_RSVD6      = 3'd6,
        MODE_RSVD7      = 3'd7
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CONTROL        = 3'd0,
        REG_GAIN           = 3'd1,
        REG_DECAY_RATE     = 3'd2,
        REG_RANGE_LOW      = 3'd3,
        REG_RANGE_HIGH     = 3'd4,
        REG_DEAD_ZONE_LOW  = 3'd5,
        REG_DEAD_ZONE_HIGH = 3'd6,
        REG_REST_VALUE     = 3'd7
    } t_cfg_reg;

    localparam logic [CTRL_W-1:0]        CONTROL_RST    = 4'd0;
    localparam logic [DATA_W-1:0]        GAIN_RST       = 16'd256;
    localparam logic [DATA_W-1:0]        DECAY_RST      = 16'd0;
    localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = -16'sd4096;
    localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 16'sd4096;
    localparam logic signed [DATA_W-1:0] DEAD_LOW_RST   = 16'sd0;
    localparam logic signed [DATA_W-1:0] DEAD_HIGH_RST  = 16'sd0;
    localparam logic signed [DATA_W-1:0] REST_RST       = 16'sd0;

endpackage

@@ rtl/input_axis_ramp_decay_clamp.sv @@
// ----------------------------------------------------------------------------
// input_axis_ramp_decay_clamp
// Virtual input axis: movement, button ramp with gravity decay, stick map
// with dead zone, invert, saturation and range clamp on one Q4.12 value.
// ----------------------------------------------------------------------------
// Each accepted word passes the input register, then the result register.
// Throughput: 1 word per cycle while not stalled; the axis accumulator is
// updated in the same cycle the result register loads, so each word sees
// the previous result. One shared 18x18 multiplier serves move gain, rate
// step and stick map. Reset (synchronous, active low): valids and
// accumulator cleared, config registers return to their defaults.
module input_axis_ramp_decay_clamp #(
    parameter int VALUE_BITS = iardc_pkg::VALUE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [iardc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [iardc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [15:0] tick_seconds, [16] device_present, [17] button_down,
    // [33:18] cursor_move, [49:34] stick_sample, [55:50] zero
    input  logic [iardc_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [15:0] axis_out
    output logic [iardc_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int DW = iardc_pkg::DATA_W;
    localparam int WW = iardc_pkg::WORK_W;
    localparam int MW = iardc_pkg::MUL_W;
    localparam int PW = 2 * MW;

    localparam logic signed [WW-1:0] SAT_MAX  = (WW'(1) <<< (VALUE_BITS - 1)) - WW'(1);
    localparam logic signed [WW-1:0] SAT_MIN  = -SAT_MAX - WW'(1);
    localparam logic signed [WW-1:0] RND_Q12  = WW'(2048);
    localparam logic signed [WW-1:0] RND_Q16  = WW'(32768);
    localparam logic signed [WW-1:0] ZERO_W   = WW'(0);
    localparam logic [DW:0]          U_ONE    = 17'h10000;

    function automatic logic signed [WW-1:0] f_sat(input logic signed [WW-1:0] x);
        logic signed [WW-1:0] y;
        y = x;
        if (x > SAT_MAX) begin
            y = SAT_MAX;
        end else if (x < SAT_MIN) begin
            y = SAT_MIN;
        end
        return y;
    endfunction

    // ---------------- config registers ----------------
    logic [iardc_pkg::CTRL_W-1:0] r_control;
    logic [DW-1:0]                r_gain;
    logic [DW-1:0]                r_decay_rate;
    logic signed [DW-1:0]         r_range_low;
    logic signed [DW-1:0]         r_range_high;
    logic signed [DW-1:0]         r_dead_low;
    logic signed [DW-1:0]         r_dead_high;
    logic signed [DW-1:0]         r_rest_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control    <= iardc_pkg::CONTROL_RST;
            r_gain       <= iardc_pkg::GAIN_RST;
            r_decay_rate <= iardc_pkg::DECAY_RST;
            r_range_low  <= iardc_pkg::RANGE_LOW_RST;
            r_range_high <= iardc_pkg::RANGE_HIGH_RST;
            r_dead_low   <= iardc_pkg::DEAD_LOW_RST;
            r_dead_high  <= iardc_pkg::DEAD_HIGH_RST;
            r_rest_value <= iardc_pkg::REST_RST;
        end else if (i_cfg_we) begin
            unique case (iardc_pkg::t_cfg_reg'(i_cfg_addr))
                iardc_pkg::REG_CONTROL:        r_control    <= i_cfg_data[iardc_pkg::CTRL_W-1:0];
                iardc_pkg::REG_GAIN:           r_gain       <= i_cfg_data;
                iardc_pkg::REG_DECAY_RATE:     r_decay_rate <= i_cfg_data;
                iardc_pkg::REG_RANGE_LOW:      r_range_low  <= i_cfg_data;
                iardc_pkg::REG_RANGE_HIGH:     r_range_high <= i_cfg_data;
                iardc_pkg::REG_DEAD_ZONE_LOW:  r_dead_low   <= i_cfg_data;
                iardc_pkg::REG_DEAD_ZONE_HIGH: r_dead_high  <= i_cfg_data;
                iardc_pkg::REG_REST_VALUE:     r_rest_value <= i_cfg_data;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                 r_s1_valid;
    logic [DW-1:0]        r_s1_tick;
    logic                 r_s1_present;
    logic                 r_s1_down;
    logic signed [DW-1:0] r_s1_move;
    logic signed [DW-1:0] r_s1_sample;

    logic                 r_out_valid;
    logic [DW-1:0]        r_out_data;
    logic signed [DW-1:0] r_accum;

    logic s1_adv;
    logic s_accept;

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_tick    <= i_s_axis_tdata[15:0];
            r_s1_present <= i_s_axis_tdata[16];
            r_s1_down    <= i_s_axis_tdata[17];
            r_s1_move    <= i_s_axis_tdata[33:18];
            r_s1_sample  <= i_s_axis_tdata[49:34];
        end
    end

    // ---------------- datapath ----------------
    iardc_pkg::t_mode     mode;
    logic                 inv;
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] dlo;
    logic signed [DW-1:0] dhi;
    logic signed [DW:0]   span;
    logic [DW:0]          u_fwd;
    logic [DW:0]          u;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [WW-1:0] prod_w;
    logic signed [WW-1:0] lo_w;
    logic signed [WW-1:0] hi_w;
    logic signed [WW-1:0] accum_w;
    logic signed [WW-1:0] rest_w;
    logic signed [WW-1:0] move_delta;
    logic signed [WW-1:0] rate_step;
    logic signed [WW-1:0] move_val;
    logic signed [WW-1:0] btn_val;
    logic signed [WW-1:0] dv;
    logic signed [WW-1:0] dmag;
    logic signed [WW-1:0] decay_val;
    logic signed [WW-1:0] stick_val;
    logic                 outside_dz;
    logic signed [WW-1:0] v_pre;
    logic signed [WW-1:0] v_clamp;

    always_comb begin
        mode = iardc_pkg::t_mode'(r_control[2:0]);
        inv  = r_control[3];

        // reversed bounds are swapped
        lo   = (r_range_low < r_range_high) ? r_range_low : r_range_high;
        hi   = (r_range_low < r_range_high) ? r_range_high : r_range_low;
        dlo  = (r_dead_low < r_dead_high) ? r_dead_low : r_dead_high;
        dhi  = (r_dead_low < r_dead_high) ? r_dead_high : r_dead_low;
        span = {hi[DW-1], hi} - {lo[DW-1], lo};

        // u = sample + 1/2 in Q0.16, mirrored by invert
        u_fwd = {1'b0, ~r_s1_sample[DW-1], r_s1_sample[DW-2:0]};
        u     = inv ? (U_ONE - u_fwd) : u_fwd;

        // one shared multiplier, operands picked by mode
        if (mode == iardc_pkg::MODE_MOVE) begin
            mul_a = {{(MW-DW){r_s1_move[DW-1]}}, r_s1_move};
            mul_b = {{(MW-DW){1'b0}}, r_gain};
        end else if (mode == iardc_pkg::MODE_STICK_AXIS) begin
            mul_a = {{(MW-DW-1){1'b0}}, u};
            mul_b = {{(MW-DW-1){span[DW]}}, span};
        end else begin
            mul_a = {{(MW-DW){1'b0}}, r_s1_tick};
            mul_b = {{(MW-DW){1'b0}}, (r_s1_down ? r_gain : r_decay_rate)};
        end
        prod   = mul_a * mul_b;
        prod_w = {{(WW-PW){prod[PW-1]}}, prod};

        lo_w    = {{(WW-DW){lo[DW-1]}}, lo};
        hi_w    = {{(WW-DW){hi[DW-1]}}, hi};
        accum_w = {{(WW-DW){r_accum[DW-1]}}, r_accum};
        rest_w  = {{(WW-DW){r_rest_value[DW-1]}}, r_rest_value};

        // Q8.8 counts to Q4.12, and Q8.24 rounded to Q4.12
        move_delta = f_sat(prod_w <<< 4);
        rate_step  = f_sat((prod_w + RND_Q12) >>> 12);

        move_val = f_sat(inv ? (rest_w - move_delta) : (rest_w + move_delta));
        btn_val  = f_sat(inv ? (accum_w - rate_step) : (accum_w + rate_step));

        // gravity toward zero; snap when the step overshoots the new magnitude
        dv   = (accum_w > ZERO_W) ? (accum_w - rate_step) : (accum_w + rate_step);
        dmag = (dv < ZERO_W) ? -dv : dv;
        if (accum_w == ZERO_W) begin
            decay_val = accum_w;
        end else if (rate_step > dmag) begin
            decay_val = ZERO_W;
        end else begin
            decay_val = f_sat(dv);
        end

        // lo + (u * (hi - lo) + half) >> 16
        stick_val  = f_sat(lo_w + ((prod_w + RND_Q16) >>> 16));
        outside_dz = (r_s1_sample < dlo) || (r_s1_sample > dhi);

        unique case (mode)
            iardc_pkg::MODE_MOVE: begin
                v_pre = r_s1_present ? move_val : rest_w;
            end
            iardc_pkg::MODE_MOUSE_BTN,
            iardc_pkg::MODE_KEY,
            iardc_pkg::MODE_STICK_BTN: begin
                if (!r_s1_present) begin
                    v_pre = accum_w;
                end else if (r_s1_down) begin
                    v_pre = btn_val;
                end else begin
                    v_pre = decay_val;
                end
            end
            iardc_pkg::MODE_STICK_AXIS: begin
                v_pre = (r_s1_present && outside_dz) ? stick_val : rest_w;
            end
            default: begin
                // scroll and unused modes hold
                v_pre = accum_w;
            end
        endcase

        v_clamp = v_pre;
        if (v_pre < lo_w) begin
            v_clamp = lo_w;
        end else if (v_pre > hi_w) begin
            v_clamp = hi_w;
        end
    end

    // ---------------- result register and accumulator ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_accum     <= '0;
        end else begin
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_accum     <= v_clamp[DW-1:0];
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= v_clamp[DW-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

@@ rtl/iardc_checker.sv @@
// ----------------------------------------------------------------------------
// iardc_checker
// Port-level checks for input_axis_ramp_decay_clamp, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iardc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [iardc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // no result word right after reset
    `ASSERT_AFTER_RESET(a_rst_empty, i_clk, i_rst_n, !o_m_axis_tvalid)

    // with the result register empty the input side is never blocked
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)

    // a word taken while the output stalls fills the input register, so
    // the next ready follows the downstream ready
    `ASSERT_NEXT(a_fill_on_stall, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && o_m_axis_tvalid && !i_m_axis_tready, o_s_axis_tready == i_m_axis_tready)

endmodule

bind input_axis_ramp_decay_clamp iardc_checker u_iardc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
